[rtl/uhp_pkg.sv]
package uhp_pkg;

    localparam int NUM_STAGES = 5;
    localparam int NUM_LANES  = 4;
    localparam int COEF_W     = 24;
    localparam int HI_W       = 6;

    localparam logic signed [24:0] MODQ       = 25'sd8380417;
    localparam logic signed [24:0] ROUND_ADD  = 25'sd127;
    localparam logic signed [14:0] APPROX_MUL = 15'sd11275;
    localparam logic signed [32:0] APPROX_RND = 33'sd8388608;
    localparam logic signed [8:0]  HI_MAX_S   = 9'sd43;
    localparam logic [HI_W-1:0]    HI_MAX     = 6'd43;
    localparam logic [23:0]        GAMMA2X2   = 24'd190464;
    localparam logic signed [25:0] LO_HALF    = 26'sd4190208;
    localparam logic signed [25:0] LO_MODQ    = 26'sd8380417;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctrl_t;

endpackage

[rtl/uhp_ctrl.sv]
module uhp_ctrl
    import uhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    // A stage loads when it is empty or when its contents move on.
    always_comb
    begin
        ctrl.en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !result_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ctrl.en[k] = !valid_reg[k] || ctrl.en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.en[0])
        begin
            valid_next[0] = item_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (ctrl.en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign item_stall   = !ctrl.en[0];
    assign result_valid = valid_reg[NUM_STAGES-1];

endmodule

[rtl/uhp_lane.sv]
module uhp_lane
    import uhp_pkg::*;
(
    input  logic              clk,
    input  pipe_ctrl_t        ctrl,
    input  logic [COEF_W-1:0] coef,
    input  logic              hint,
    output logic [HI_W-1:0]   hi
);

    logic signed [24:0] coef_ext;
    logic signed [24:0] v_next;
    logic signed [24:0] v_rnd;

    logic signed [24:0] v1_reg;
    logic signed [17:0] a_reg;
    logic               h1_reg;

    logic signed [24:0] v2_reg;
    logic signed [32:0] prod_reg;
    logic signed [32:0] prod_next;
    logic               h2_reg;

    logic signed [24:0] v3_reg;
    logic [HI_W-1:0]    hi3_reg;
    logic [HI_W-1:0]    hi3_next;
    logic signed [32:0] sum;
    logic signed [8:0]  hi_raw;
    logic               h3_reg;

    logic [HI_W-1:0]    hi4_reg;
    logic signed [25:0] lo_reg;
    logic signed [25:0] lo_next;
    logic [23:0]        hi_scaled;
    logic               h4_reg;

    logic [HI_W-1:0]    hi5_reg;
    logic [HI_W-1:0]    hi5_next;
    logic               lo_pos;

    always_comb
    begin
        coef_ext = {coef[COEF_W-1], coef};
        v_next   = coef[COEF_W-1] ? coef_ext + MODQ : coef_ext;
        v_rnd    = v_next + ROUND_ADD;
    end

    assign prod_next = 33'(a_reg * APPROX_MUL);

    always_comb
    begin
        sum    = prod_reg + APPROX_RND;
        hi_raw = sum[32:24];
        if (hi_raw[8] || hi_raw > HI_MAX_S)
        begin
            hi3_next = '0;
        end
        else
        begin
            hi3_next = hi_raw[HI_W-1:0];
        end
    end

    always_comb
    begin
        hi_scaled = 24'(hi3_reg) * GAMMA2X2;
        lo_next   = {v3_reg[24], v3_reg} - $signed({2'b00, hi_scaled});
    end

    // The centered low part is positive in the lower half of the range, or
    // above the modulus where the centering subtraction leaves it positive.
    always_comb
    begin
        lo_pos   = (lo_reg > 26'sd0 && lo_reg <= LO_HALF) || lo_reg > LO_MODQ;
        hi5_next = hi4_reg;
        if (h4_reg)
        begin
            if (lo_pos)
            begin
                hi5_next = (hi4_reg == HI_MAX) ? '0 : hi4_reg + 6'd1;
            end
            else
            begin
                hi5_next = (hi4_reg == '0) ? HI_MAX : hi4_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            v1_reg <= v_next;
            a_reg  <= v_rnd[24:7];
            h1_reg <= hint;
        end
        if (ctrl.en[1])
        begin
            v2_reg   <= v1_reg;
            prod_reg <= prod_next;
            h2_reg   <= h1_reg;
        end
        if (ctrl.en[2])
        begin
            v3_reg  <= v2_reg;
            hi3_reg <= hi3_next;
            h3_reg  <= h2_reg;
        end
        if (ctrl.en[3])
        begin
            hi4_reg <= hi3_reg;
            lo_reg  <= lo_next;
            h4_reg  <= h3_reg;
        end
        if (ctrl.en[4])
        begin
            hi5_reg <= hi5_next;
        end
    end

    assign hi = hi5_reg;

endmodule

[rtl/use_hint_high_bits_pack.sv]
// Applies ML-DSA-44 hints to four coefficients per transfer and packs the
// four 6-bit high parts into three bytes. The block is a five-stage pipeline
// that accepts one transfer per cycle while it is not stalled; each result is
// offered once its transfer has passed through every stage, and a stall on the
// result side holds the pipeline while empty stages still fill.
module use_hint_high_bits_pack
    import uhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [COEF_W-1:0] coef0,
    input  logic [COEF_W-1:0] coef1,
    input  logic [COEF_W-1:0] coef2,
    input  logic [COEF_W-1:0] coef3,
    input  logic              hint0,
    input  logic              hint1,
    input  logic              hint2,
    input  logic              hint3,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        packed_byte0,
    output logic [7:0]        packed_byte1,
    output logic [7:0]        packed_byte2
);

    pipe_ctrl_t ctrl;
    logic [HI_W-1:0] hi0;
    logic [HI_W-1:0] hi1;
    logic [HI_W-1:0] hi2;
    logic [HI_W-1:0] hi3;

    uhp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctrl         (ctrl)
    );

    uhp_lane u_lane0 (.clk(clk), .ctrl(ctrl), .coef(coef0), .hint(hint0), .hi(hi0));
    uhp_lane u_lane1 (.clk(clk), .ctrl(ctrl), .coef(coef1), .hint(hint1), .hi(hi1));
    uhp_lane u_lane2 (.clk(clk), .ctrl(ctrl), .coef(coef2), .hint(hint2), .hi(hi2));
    uhp_lane u_lane3 (.clk(clk), .ctrl(ctrl), .coef(coef3), .hint(hint3), .hi(hi3));

    assign packed_byte0 = {hi1[1:0], hi0};
    assign packed_byte1 = {hi2[3:0], hi1[5:2]};
    assign packed_byte2 = {hi3, hi2[5:4]};

endmodule
